### rtl/cfah_pkg.sv
// ----------------------------------------------------------------------------
// cfah_pkg
// Shared widths, constants and types for the case-folded Adler-style hash.
// ----------------------------------------------------------------------------
package cfah_pkg;

   localparam int SumWidth  = 16;
   localparam int ByteWidth = 8;
   localparam int HashWidth = 2 * SumWidth;

   localparam logic [SumWidth-1:0]  AdlerMod    = 16'd65521;
   localparam logic [ByteWidth-1:0] UpperFirst  = 8'h41;
   localparam logic [ByteWidth-1:0] UpperLast   = 8'h5A;
   localparam logic [ByteWidth-1:0] CaseOffset  = 8'h20;

   typedef logic [SumWidth-1:0]  sum_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [HashWidth-1:0] hash_type;

   typedef struct packed {
      sum_type sum_one;
      sum_type sum_two;
   } sums_type;

endpackage

### rtl/cfah_channels.sv
// ----------------------------------------------------------------------------
// cfah channels
// Valid/ready channel interfaces for the byte input and the hash result.
// ----------------------------------------------------------------------------
interface cfah_req_if
   import cfah_pkg::*;
   ();
   logic     valid;
   logic     ready;
   byte_type char_byte;
   logic     is_last;

   modport source (output valid, output char_byte, output is_last, input ready);
   modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface cfah_rsp_if
   import cfah_pkg::*;
   ();
   logic     valid;
   logic     ready;
   hash_type hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

### rtl/cfah_sum_unit.sv
// ----------------------------------------------------------------------------
// cfah_sum_unit
// Folds one byte to lower case and advances both running sums modulo 65521.
// ----------------------------------------------------------------------------
module cfah_sum_unit
   import cfah_pkg::*;
(
   input  byte_type char_byte,
   input  sums_type sums_cur,
   output sums_type sums_next
);

   byte_type             folded;
   logic [SumWidth:0]    raw_one;
   logic [SumWidth:0]    raw_two;
   sum_type              red_one;

   always_comb begin
      if (char_byte inside {[UpperFirst:UpperLast]}) begin
         folded = char_byte + CaseOffset;
      end else begin
         folded = char_byte;
      end
   end

   // both sums stay below the modulus, so one conditional subtract is enough
   always_comb begin
      raw_one = {1'b0, sums_cur.sum_one} + {{(SumWidth+1-ByteWidth){1'b0}}, folded};
      if (raw_one >= {1'b0, AdlerMod}) begin
         red_one = SumWidth'(raw_one - {1'b0, AdlerMod});
      end else begin
         red_one = raw_one[SumWidth-1:0];
      end
      raw_two = {1'b0, sums_cur.sum_two} + {1'b0, red_one};
      sums_next.sum_one = red_one;
      if (raw_two >= {1'b0, AdlerMod}) begin
         sums_next.sum_two = SumWidth'(raw_two - {1'b0, AdlerMod});
      end else begin
         sums_next.sum_two = raw_two[SumWidth-1:0];
      end
   end

endmodule

### rtl/case_folded_adler_hash.sv
// ----------------------------------------------------------------------------
// case_folded_adler_hash
// Byte-serial case-folded Adler-style hash with zero start value for sum one.
// ----------------------------------------------------------------------------
//  channel | dir | payload               | transfer
//  req     | in  | char_byte, is_last    | req.valid && req.ready
//  rsp     | out | hash_value            | rsp.valid && rsp.ready
//
//  one byte per cycle sustained; a byte goes into an input register, then the
//  sum unit updates the sums and, on the last byte, loads the result register
//  result valid is registered and is set as the last byte leaves the input register
//  reset clears the valid bits and both sums
//  a held result stalls only a last byte waiting in the input register, and
//  req.ready drops with it; non-last bytes in that register keep flowing
// ----------------------------------------------------------------------------
module case_folded_adler_hash
   import cfah_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cfah_req_if.sink   req,
   cfah_rsp_if.source rsp
);

   logic     in_valid_ff;
   byte_type in_byte_ff;
   logic     in_last_ff;

   sums_type sums_ff;
   sums_type sums_in;
   sums_type sums_step;

   logic     out_valid_ff;
   hash_type out_hash_ff;

   logic     out_free;
   logic     advance;

   cfah_sum_unit u_sum (
      .char_byte (in_byte_ff),
      .sums_cur  (sums_ff),
      .sums_next (sums_step)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   // a non-last byte needs no room in the result register
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      sums_in = sums_ff;
      if (advance) begin
         if (in_last_ff) begin
            sums_in = '0;
         end else begin
            sums_in = sums_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sums_ff      <= '0;
      end else begin
         sums_ff <= sums_in;
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.char_byte;
         in_last_ff <= req.is_last;
      end
      if (advance && in_last_ff) begin
         out_hash_ff <= {sums_step.sum_two, sums_step.sum_one};
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.hash_value = out_hash_ff;

endmodule
